### design/rcfd_pkg.sv
// rcfd_pkg: shared types, byte codes and register indexes for the remote
// command frame decoder. No dependencies.
package rcfd_pkg;

  localparam logic [7:0] CHAR_START = 8'h73;  // 's'
  localparam logic [7:0] CHAR_END   = 8'h65;  // 'e'
  localparam logic [7:0] CHAR_SEP   = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [15:0] DUTY_RESET = 16'd1560;

  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_CENTER = 2'd0;
  localparam logic [1:0] REG_LEFT   = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,  // between tokens
    PH_SPACE  = 4'b0010,  // leading whitespace seen
    PH_DIGITS = 4'b0100,  // sign or digits seen
    PH_DONE   = 4'b1000   // token finished, rest ignored
  } rcfd_phase_t;

  typedef struct packed {
    logic [31:0] start_value;
    logic [31:0] head_button;
    logic [31:0] back_button;
    logic [31:0] right_button;
    logic [31:0] left_button;
  } rcfd_frame_t;

  typedef struct packed {
    logic [15:0] center;
    logic [15:0] left_limit;
    logic [15:0] right_limit;
  } rcfd_cfg_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

### design/rcfd_cfg_regs.sv
// rcfd_cfg_regs: APB-style register file for the steering duty settings.
// Depends on rcfd_pkg.
module rcfd_cfg_regs
  import rcfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output rcfd_cfg_t             cfg
);

  rcfd_cfg_t cfg_r;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center      <= DUTY_RESET;
      cfg_r.left_limit  <= DUTY_RESET;
      cfg_r.right_limit <= DUTY_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CENTER: cfg_r.center      <= pwdata[15:0];
        REG_LEFT:   cfg_r.left_limit  <= pwdata[15:0];
        REG_RIGHT:  cfg_r.right_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CENTER: prdata = {16'd0, cfg_r.center};
      REG_LEFT:   prdata = {16'd0, cfg_r.left_limit};
      REG_RIGHT:  prdata = {16'd0, cfg_r.right_limit};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

### design/rcfd_parser.sv
// rcfd_parser: input byte register and frame tokenizer; hands one frame of
// captured fields per accepted 'e'. Depends on rcfd_pkg.
module rcfd_parser
  import rcfd_pkg::*;
#(
  parameter int MAX_FRAME_CHARS = 99,
  parameter int FIELD_COUNT     = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        frame_valid,
  input  logic        frame_ready,
  output rcfd_frame_t frame
);

  localparam int LEN_W  = $clog2(MAX_FRAME_CHARS + 2);
  localparam int FIDX_W = $clog2(FIELD_COUNT + 1);

  // byte stage
  logic        b_v_r;
  logic [7:0]  byte_r;
  logic        p_go;
  logic        frame_free;

  // token state
  logic              in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [FIDX_W-1:0] fidx_r, fidx_nxt, fidx_cl;
  rcfd_phase_t       phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic              ended_r, ended_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [31:0]       cap_r [5];
  logic [31:0]       cap_nxt [5];
  logic [31:0]       cap_cl [5];
  logic [31:0]       tok_val;
  logic [31:0]       digit_val;
  logic              do_close;

  // frame output stage
  logic        frame_valid_r, frame_valid_nxt;
  logic        emit;
  rcfd_frame_t frame_r, frame_nxt;

  assign frame_free  = !frame_valid_r || frame_ready;
  assign p_go        = b_v_r && frame_free;
  assign in_ready    = !b_v_r || p_go;
  assign frame_valid = frame_valid_r;
  assign frame       = frame_r;
  assign digit_val   = {28'd0, byte_r[3:0]};

  // value of the open token closed now, and the field array after the close
  always_comb begin
    tok_val = neg_r ? (32'd0 - val_r) : val_r;
    cap_cl  = cap_r;
    if (fidx_r <= FIDX_W'(3)) begin
      cap_cl[{1'b0, fidx_r[1:0]}] = tok_val;
    end else if (fidx_r == FIDX_W'(5)) begin
      cap_cl[4] = tok_val;
    end
    fidx_cl = (fidx_r < FIDX_W'(FIELD_COUNT)) ? fidx_r + 1'b1 : fidx_r;
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    len_nxt      = len_r;
    fidx_nxt     = fidx_r;
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    ended_nxt    = ended_r;
    val_nxt      = val_r;
    cap_nxt      = cap_r;
    do_close     = 1'b0;
    emit         = 1'b0;
    frame_nxt    = frame_r;
    if (p_go) begin
      priority if (byte_r == CHAR_START) begin
        in_frame_nxt = 1'b1;
        len_nxt      = '0;
        fidx_nxt     = '0;
        phase_nxt    = PH_IDLE;
        neg_nxt      = 1'b0;
        ended_nxt    = 1'b0;
        val_nxt      = 32'd0;
        for (int i = 0; i < 5; i++) cap_nxt[i] = 32'd0;
      end else if (!in_frame_r) begin
        // stray byte between frames
      end else if (byte_r != CHAR_END) begin
        if (len_r <= LEN_W'(MAX_FRAME_CHARS)) len_nxt = len_r + 1'b1;
        if (!ended_r) begin
          priority if (byte_r == CHAR_NUL) begin
            do_close  = (phase_r != PH_IDLE);
            ended_nxt = 1'b1;
          end else if (byte_r == CHAR_SEP) begin
            do_close = (phase_r != PH_IDLE);
          end else begin
            unique case (phase_r)
              PH_IDLE, PH_SPACE: begin
                priority if (is_space(byte_r)) begin
                  phase_nxt = PH_SPACE;
                end else if (byte_r == CHAR_PLUS || byte_r == CHAR_MINUS) begin
                  neg_nxt   = (byte_r == CHAR_MINUS);
                  phase_nxt = PH_DIGITS;
                end else if (is_digit(byte_r)) begin
                  val_nxt   = digit_val;
                  phase_nxt = PH_DIGITS;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
              PH_DIGITS: begin
                if (is_digit(byte_r)) begin
                  // times ten as two shifts
                  val_nxt = {val_r[28:0], 3'b000} + {val_r[30:0], 1'b0} + digit_val;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
              PH_DONE: ;
              default: ;
            endcase
          end
        end
      end else begin
        // closing 'e': within the length limit it ends the open token unless the body ended
        in_frame_nxt = 1'b0;
        if (len_r < LEN_W'(MAX_FRAME_CHARS)) begin
          emit = 1'b1;
          if (ended_r) begin
            frame_nxt = '{cap_r[0], cap_r[1], cap_r[2], cap_r[3], cap_r[4]};
          end else begin
            frame_nxt = '{cap_cl[0], cap_cl[1], cap_cl[2], cap_cl[3], cap_cl[4]};
          end
        end
      end
    end
    if (do_close) begin
      cap_nxt   = cap_cl;
      fidx_nxt  = fidx_cl;
      phase_nxt = PH_IDLE;
      neg_nxt   = 1'b0;
      val_nxt   = 32'd0;
    end
    frame_valid_nxt = emit ? 1'b1 : (frame_ready ? 1'b0 : frame_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r         <= 1'b0;
      in_frame_r    <= 1'b0;
      len_r         <= '0;
      fidx_r        <= '0;
      phase_r       <= PH_IDLE;
      neg_r         <= 1'b0;
      ended_r       <= 1'b0;
      val_r         <= 32'd0;
      frame_valid_r <= 1'b0;
    end else begin
      if (in_ready) b_v_r <= in_valid;
      in_frame_r    <= in_frame_nxt;
      len_r         <= len_nxt;
      fidx_r        <= fidx_nxt;
      phase_r       <= phase_nxt;
      neg_r         <= neg_nxt;
      ended_r       <= ended_nxt;
      val_r         <= val_nxt;
      frame_valid_r <= frame_valid_nxt;
    end
  end

  // payload: fields are cleared by every 's' before use
  always_ff @(posedge clk) begin
    if (in_ready) byte_r <= in_byte;
    cap_r   <= cap_nxt;
    frame_r <= frame_nxt;
  end

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    p_go && byte_r == CHAR_START |=> in_frame_r && len_r == '0 && fidx_r == '0)
    else $error("frame start did not clear tokenizer state");

  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> len_r <= LEN_W'(MAX_FRAME_CHARS + 1))
    else $error("frame length passed its saturation point");

  a_sep_closes: assert property (@(posedge clk) disable iff (!rst_n)
    p_go && in_frame_r && byte_r == CHAR_SEP |=> phase_r == PH_IDLE && !neg_r)
    else $error("separator left a token open");

endmodule

### design/rcfd_frame_ctrl.sv
// rcfd_frame_ctrl: per-frame drive mode, stop flag and steering duty update,
// plus the result register. Depends on rcfd_pkg.
module rcfd_frame_ctrl
  import rcfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        frame_valid,
  output logic        frame_ready,
  input  rcfd_frame_t frame,
  input  rcfd_cfg_t   cfg,
  output logic        out_valid,
  input  logic        out_ready,
  output rcfd_frame_t out_frame,
  output logic [15:0] out_mode,
  output logic        out_stop,
  output logic [15:0] out_duty
);

  logic        c_fire;
  logic        out_valid_r;
  logic [31:0] prev_head_r, prev_back_r;
  logic [15:0] mode_r, mode_nxt;
  logic        stop_r, stop_nxt;
  logic [15:0] duty_nxt;
  rcfd_frame_t out_frame_r;
  logic [15:0] out_duty_r;

  assign frame_ready = !out_valid_r || out_ready;
  assign c_fire      = frame_valid && frame_ready;
  assign out_valid   = out_valid_r;
  assign out_frame   = out_frame_r;
  assign out_mode    = mode_r;
  assign out_stop    = stop_r;
  assign out_duty    = out_duty_r;

  always_comb begin
    mode_nxt = mode_r;
    stop_nxt = stop_r;
    // head rising edge then back rising edge; start of zero wins over both
    if (prev_head_r == 32'd0 && frame.head_button == 32'd1) begin
      mode_nxt = mode_nxt + 16'd1;
      stop_nxt = 1'b0;
    end
    if (prev_back_r == 32'd0 && frame.back_button == 32'd1) begin
      mode_nxt = mode_nxt - 16'd1;
      stop_nxt = 1'b1;
    end
    if (frame.start_value == 32'd0) mode_nxt = 16'd0;

    priority if (frame.right_button == 32'd0) duty_nxt = cfg.left_limit;
    else if (frame.left_button == 32'd0)      duty_nxt = cfg.right_limit;
    else                                      duty_nxt = cfg.center;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_head_r <= 32'd1;
      prev_back_r <= 32'd1;
      mode_r      <= 16'd0;
      stop_r      <= 1'b1;
    end else begin
      if (frame_ready) out_valid_r <= frame_valid;
      if (c_fire) begin
        prev_head_r <= frame.head_button;
        prev_back_r <= frame.back_button;
        mode_r      <= mode_nxt;
        stop_r      <= stop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_fire) begin
      out_frame_r <= frame;
      out_duty_r  <= duty_nxt;
    end
  end

  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    c_fire && frame.start_value == 32'd0 |=> mode_r == 16'd0)
    else $error("zero start value did not clear drive mode");

  a_out_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(c_fire))
    else $error("result appeared without a frame");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_frame_r) &&
                                  $stable(out_duty_r) && $stable(mode_r))
    else $error("stalled result changed");

endmodule

### design/remote_command_frame_decoder.sv
// remote_command_frame_decoder: top level of the serial remote command frame
// decoder. Depends on rcfd_pkg, rcfd_cfg_regs, rcfd_parser, rcfd_frame_ctrl.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in_     | slave     | in_tvalid / in_tready  | in_tdata[7:0] = rx_byte
//  out_    | master    | out_tvalid/out_tready  | out_tdata[199:0], see port
//  cfg_    | APB slave | psel/penable, pready=1 | three 16-bit duty registers
//
// One byte per cycle is taken while in_tready is high. Bytes pass an input
// register, then the tokenizer, which on a closing 'e' loads a frame
// register; the frame logic then loads the result register.
// Reset is synchronous (rst_n low) and needs no sweep.
// A stalled result holds in the output register while the frame register and
// the input register still fill; in_tready drops only when all three are held.
module remote_command_frame_decoder
  import rcfd_pkg::*;
#(
  parameter int MAX_FRAME_CHARS = 99,  // longest frame body incl. closing 'e'
  parameter int FIELD_COUNT     = 10   // tokens counted per frame
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input byte stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,     // [7:0] rx_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] start_value, [63:32] head_button, [95:64] back_button,
  // [127:96] right_button, [159:128] left_button, [175:160] drive_mode,
  // [176] stop_sign, [192:177] steer_duty, [199:193] zero
  output logic [199:0]          out_tdata,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  rcfd_cfg_t   cfg;
  logic        frame_valid;
  logic        frame_ready;
  rcfd_frame_t frame;
  rcfd_frame_t res_frame;
  logic [15:0] res_mode;
  logic        res_stop;
  logic [15:0] res_duty;

  rcfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // tokenizer: frame delimiting, atoi per token, field capture
  rcfd_parser #(
    .MAX_FRAME_CHARS (MAX_FRAME_CHARS),
    .FIELD_COUNT     (FIELD_COUNT)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_byte     (in_tdata),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  // button edge detection, mode counter, duty select, result register
  rcfd_frame_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .cfg         (cfg),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_frame   (res_frame),
    .out_mode    (res_mode),
    .out_stop    (res_stop),
    .out_duty    (res_duty)
  );

  assign out_tdata = {7'd0, res_duty, res_stop, res_mode,
                      res_frame.left_button, res_frame.right_button,
                      res_frame.back_button, res_frame.head_button,
                      res_frame.start_value};

endmodule
